>>> src/vam_pkg.sv
`default_nettype none

package vam_pkg;

   localparam int NUM_COND            = 9;
   localparam int COND_ID_W           = 4;
   localparam int COUNT_W             = 32;
   localparam int TIME_W              = 32;
   localparam int CSR_INDEX_W         = 3;
   localparam int CSR_DATA_W          = 15;
   localparam int REMINDER_MS_DEFAULT = 5000;

   localparam logic [COND_ID_W-1:0] LAST_COND = COND_ID_W'(NUM_COND - 1);

   // critical conditions: engine, battery, overspeed and tire critical
   localparam logic [NUM_COND-1:0] COND_CRITICAL = 9'b0_0011_0101;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TEMP_WARN    = 3'd0,
      CSR_TEMP_CRIT    = 3'd1,
      CSR_BATTERY_WARN = 3'd2,
      CSR_BATTERY_CRIT = 3'd3,
      CSR_OVERSPEED    = 3'd4,
      CSR_TIRE_WARN    = 3'd5,
      CSR_TIRE_CRIT    = 3'd6,
      CSR_DOOR_SPEED   = 3'd7
   } csr_index_type;

   localparam logic signed [12:0] TEMP_WARN_RESET    = 13'sd1000;
   localparam logic signed [12:0] TEMP_CRIT_RESET    = 13'sd1150;
   localparam logic [14:0]        BATTERY_WARN_RESET = 15'd11500;
   localparam logic [14:0]        BATTERY_CRIT_RESET = 15'd11000;
   localparam logic [12:0]        OVERSPEED_RESET    = 13'd1500;
   localparam logic [9:0]         TIRE_WARN_RESET    = 10'd250;
   localparam logic [9:0]         TIRE_CRIT_RESET    = 10'd200;
   localparam logic [12:0]        DOOR_SPEED_RESET   = 13'd50;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_RAISE = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef action_type [NUM_COND-1:0] action_vec_type;

   typedef enum logic [1:0] {
      EV_RAISED  = 2'd0,
      EV_REMIND  = 2'd1,
      EV_CLEARED = 2'd2
   } event_kind_type;

   typedef struct packed {
      event_kind_type       kind;
      logic [COND_ID_W-1:0] cond_id;
      logic                 severity;
      logic [3:0]           active_count;
      logic [COUNT_W-1:0]   raised_total;
      logic [COUNT_W-1:0]   raised_critical;
      logic [COUNT_W-1:0]   raised_warning;
   } event_type;

   typedef struct packed {
      logic push;
      logic close;
   } push_ctl_type;

endpackage

`default_nettype wire

>>> src/vam_ram.sv
`default_nettype none

module vam_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> src/vam_classify.sv
`default_nettype none

module vam_classify (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [vam_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [vam_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  wire logic signed [12:0]                   engine_temp,
   input  wire logic [14:0]                          battery_mv,
   input  wire logic [12:0]                          speed_tenths,
   input  wire logic [9:0]                           tire_pressure,
   input  wire logic                                 door_open,
   input  wire logic                                 belt_locked,
   output vam_pkg::action_vec_type                   actions
);

   logic signed [12:0] temp_warn_ff;
   logic signed [12:0] temp_crit_ff;
   logic [14:0]        battery_warn_ff;
   logic [14:0]        battery_crit_ff;
   logic [12:0]        overspeed_ff;
   logic [9:0]         tire_warn_ff;
   logic [9:0]         tire_crit_ff;
   logic [12:0]        door_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_warn_ff    <= vam_pkg::TEMP_WARN_RESET;
         temp_crit_ff    <= vam_pkg::TEMP_CRIT_RESET;
         battery_warn_ff <= vam_pkg::BATTERY_WARN_RESET;
         battery_crit_ff <= vam_pkg::BATTERY_CRIT_RESET;
         overspeed_ff    <= vam_pkg::OVERSPEED_RESET;
         tire_warn_ff    <= vam_pkg::TIRE_WARN_RESET;
         tire_crit_ff    <= vam_pkg::TIRE_CRIT_RESET;
         door_speed_ff   <= vam_pkg::DOOR_SPEED_RESET;
      end else if (csr_wr_en) begin
         case (vam_pkg::csr_index_type'(csr_index))
            vam_pkg::CSR_TEMP_WARN:    temp_warn_ff    <= csr_wdata[12:0];
            vam_pkg::CSR_TEMP_CRIT:    temp_crit_ff    <= csr_wdata[12:0];
            vam_pkg::CSR_BATTERY_WARN: battery_warn_ff <= csr_wdata;
            vam_pkg::CSR_BATTERY_CRIT: battery_crit_ff <= csr_wdata;
            vam_pkg::CSR_OVERSPEED:    overspeed_ff    <= csr_wdata[12:0];
            vam_pkg::CSR_TIRE_WARN:    tire_warn_ff    <= csr_wdata[9:0];
            vam_pkg::CSR_TIRE_CRIT:    tire_crit_ff    <= csr_wdata[9:0];
            vam_pkg::CSR_DOOR_SPEED:   door_speed_ff   <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      actions = {vam_pkg::NUM_COND{vam_pkg::ACT_NONE}};

      if (engine_temp > temp_crit_ff) begin
         actions[0] = vam_pkg::ACT_RAISE;
      end else if (engine_temp > temp_warn_ff) begin
         actions[1] = vam_pkg::ACT_RAISE;
      end else begin
         actions[0] = vam_pkg::ACT_CLEAR;
         actions[1] = vam_pkg::ACT_CLEAR;
      end

      if (battery_mv < battery_crit_ff) begin
         actions[2] = vam_pkg::ACT_RAISE;
      end else if (battery_mv < battery_warn_ff) begin
         actions[3] = vam_pkg::ACT_RAISE;
      end else begin
         actions[2] = vam_pkg::ACT_CLEAR;
         actions[3] = vam_pkg::ACT_CLEAR;
      end

      actions[4] = (speed_tenths > overspeed_ff) ? vam_pkg::ACT_RAISE : vam_pkg::ACT_CLEAR;

      if (tire_pressure < tire_crit_ff) begin
         actions[5] = vam_pkg::ACT_RAISE;
      end else if (tire_pressure < tire_warn_ff) begin
         actions[6] = vam_pkg::ACT_RAISE;
      end else begin
         actions[5] = vam_pkg::ACT_CLEAR;
         actions[6] = vam_pkg::ACT_CLEAR;
      end

      actions[7] = (door_open && (speed_tenths > door_speed_ff)) ?
                   vam_pkg::ACT_RAISE : vam_pkg::ACT_CLEAR;

      actions[8] = (!belt_locked && (speed_tenths != 13'd0)) ?
                   vam_pkg::ACT_RAISE : vam_pkg::ACT_CLEAR;
   end

endmodule

`default_nettype wire

>>> src/vam_core.sv
`default_nettype none

module vam_core #(
   parameter int unsigned REMINDER_MS = vam_pkg::REMINDER_MS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             accept,
   input  wire vam_pkg::action_vec_type          actions,
   input  wire logic [vam_pkg::TIME_W-1:0]       time_ms,
   output logic                                  ready,
   input  wire logic                             push_ok,
   output vam_pkg::push_ctl_type                 ctl,
   output vam_pkg::event_type                    evt
);

   localparam int ID_W = vam_pkg::COND_ID_W;
   localparam int NC   = vam_pkg::NUM_COND;

   // issue stage
   logic                          s_busy_ff;
   logic [ID_W-1:0]               s_idx_ff;
   vam_pkg::action_vec_type       s_act_ff;
   logic [vam_pkg::TIME_W-1:0]    s_now_ff;

   // evaluate stage
   logic                          e_valid_ff;
   logic [ID_W-1:0]               e_id_ff;
   vam_pkg::action_type           e_act_ff;
   logic [vam_pkg::TIME_W-1:0]    e_now_ff;

   logic [NC-1:0]                 active_ff;
   logic [NC-1:0]                 active_in;
   logic [vam_pkg::COUNT_W-1:0]   total_ff, total_in;
   logic [vam_pkg::COUNT_W-1:0]   crit_ff, crit_in;
   logic [vam_pkg::COUNT_W-1:0]   warn_ff, warn_in;

   logic [vam_pkg::TIME_W-1:0]    stamp_rd;
   logic [vam_pkg::TIME_W-1:0]    elapsed;
   logic                          remind_due;
   logic                          cur_active;
   logic                          cur_crit;
   logic                          ev_raise, ev_remind, ev_clear, ev_any;
   logic                          e_stall, e_take, e_fire;
   logic                          s_adv, s_done;
   logic [3:0]                    act_count;

   assign cur_active = active_ff[e_id_ff];
   assign cur_crit   = vam_pkg::COND_CRITICAL[e_id_ff];
   assign elapsed    = e_now_ff - stamp_rd;
   assign remind_due = elapsed >= vam_pkg::TIME_W'(REMINDER_MS);

   assign ev_raise  = (e_act_ff == vam_pkg::ACT_RAISE) && !cur_active;
   assign ev_remind = (e_act_ff == vam_pkg::ACT_RAISE) && cur_active && remind_due;
   assign ev_clear  = (e_act_ff == vam_pkg::ACT_CLEAR) && cur_active;
   assign ev_any    = ev_raise || ev_remind || ev_clear;

   assign e_stall = e_valid_ff && ev_any && !push_ok;
   assign e_fire  = e_valid_ff && !e_stall;
   assign e_take  = !e_valid_ff || !e_stall;
   assign s_adv   = s_busy_ff && e_take;
   assign s_done  = s_adv && (s_idx_ff == vam_pkg::LAST_COND);
   assign ready   = !s_busy_ff || s_done;

   vam_ram #(
      .WIDTH (vam_pkg::TIME_W),
      .DEPTH (NC)
   ) u_stamp_ram (
      .clock      (clock),
      .wr_en      (e_fire && (ev_raise || ev_remind)),
      .wr_addr    (e_id_ff),
      .wr_data    (e_now_ff),
      .rd_en      (s_adv),
      .rd_addr    (s_idx_ff),
      .rd_data_ff (stamp_rd)
   );

   always_comb begin
      active_in = active_ff;
      if (ev_raise) begin
         active_in[e_id_ff] = 1'b1;
      end else if (ev_clear) begin
         active_in[e_id_ff] = 1'b0;
      end
   end

   always_comb begin
      total_in = total_ff;
      crit_in  = crit_ff;
      warn_in  = warn_ff;
      if (ev_raise) begin
         if (total_ff != '1) begin
            total_in = total_ff + vam_pkg::COUNT_W'(1);
         end
         if (cur_crit) begin
            if (crit_ff != '1) begin
               crit_in = crit_ff + vam_pkg::COUNT_W'(1);
            end
         end else if (warn_ff != '1) begin
            warn_in = warn_ff + vam_pkg::COUNT_W'(1);
         end
      end
   end

   always_comb begin
      act_count = 4'd0;
      for (int i = 0; i < NC; i++) begin
         act_count = act_count + 4'(active_in[i]);
      end
   end

   always_comb begin
      evt.kind            = ev_raise  ? vam_pkg::EV_RAISED :
                            ev_remind ? vam_pkg::EV_REMIND : vam_pkg::EV_CLEARED;
      evt.cond_id         = e_id_ff;
      evt.severity        = cur_crit;
      evt.active_count    = act_count;
      evt.raised_total    = total_in;
      evt.raised_critical = crit_in;
      evt.raised_warning  = warn_in;
      ctl.push            = e_fire && ev_any;
      ctl.close           = e_fire && (e_id_ff == vam_pkg::LAST_COND);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_busy_ff  <= 1'b0;
         e_valid_ff <= 1'b0;
         active_ff  <= '0;
         total_ff   <= '0;
         crit_ff    <= '0;
         warn_ff    <= '0;
      end else begin
         if (accept) begin
            s_busy_ff <= 1'b1;
         end else if (s_done) begin
            s_busy_ff <= 1'b0;
         end
         if (e_take) begin
            e_valid_ff <= s_adv;
         end
         if (e_fire) begin
            active_ff <= active_in;
            total_ff  <= total_in;
            crit_ff   <= crit_in;
            warn_ff   <= warn_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s_idx_ff <= '0;
         s_act_ff <= actions;
         s_now_ff <= time_ms;
      end else if (s_adv) begin
         s_idx_ff <= s_idx_ff + ID_W'(1);
      end
      if (e_take) begin
         e_id_ff  <= s_idx_ff;
         e_act_ff <= s_act_ff[s_idx_ff];
         e_now_ff <= s_now_ff;
      end
   end

endmodule

`default_nettype wire

>>> src/vam_outbuf.sv
`default_nettype none

module vam_outbuf (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire vam_pkg::push_ctl_type ctl,
   input  wire vam_pkg::event_type    evt,
   output logic                       push_ok,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output vam_pkg::event_type         rsp_evt,
   output logic                       rsp_last
);

   // hold the newest event until it is known whether it ends its snapshot
   logic               h_valid_ff;
   logic               h_closed_ff;
   vam_pkg::event_type h_evt_ff;

   logic               o_valid_ff;
   logic               o_last_ff;
   vam_pkg::event_type o_evt_ff;

   logic               o_free;
   logic               h_move;

   assign o_free  = !o_valid_ff || rsp_ready;
   assign push_ok = !h_valid_ff || o_free;
   assign h_move  = h_valid_ff && o_free && (h_closed_ff || ctl.push);

   assign rsp_valid = o_valid_ff;
   assign rsp_evt   = o_evt_ff;
   assign rsp_last  = o_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff  <= 1'b0;
         h_closed_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         if (ctl.push) begin
            h_valid_ff  <= 1'b1;
            h_closed_ff <= ctl.close;
         end else if (h_move) begin
            h_valid_ff  <= 1'b0;
         end else if (ctl.close && h_valid_ff) begin
            h_closed_ff <= 1'b1;
         end
         if (h_move) begin
            o_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            o_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         h_evt_ff <= evt;
      end
      if (h_move) begin
         o_evt_ff  <= h_evt_ff;
         o_last_ff <= h_closed_ff;
      end
   end

endmodule

`default_nettype wire

>>> src/vehicle_alert_monitor_top.sv
// Port group | Direction | Transfer when
// req_*      | in        | req_valid && req_ready, one vehicle snapshot
// rsp_*      | out       | rsp_valid && rsp_ready, one alert event
// csr_*      | in        | csr_wr_en, one threshold register write
//
// A snapshot issues one reminder-stamp RAM read per condition, 0..8.
// The next snapshot is taken while condition 8 of the current one issues.
// Events go from evaluation to the hold register, then the output register; the
// last event of a snapshot stays held until condition 8 is evaluated.
// rsp_ready low stalls an event once the hold and output registers are full.
// Sync reset clears flags and counters, presets thresholds; no clearing pass.
`default_nettype none

module vehicle_alert_monitor_top #(
   parameter int unsigned REMINDER_MS = vam_pkg::REMINDER_MS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic signed [12:0]                 req_engine_temp,
   input  wire logic [14:0]                        req_battery_mv,
   input  wire logic [12:0]                        req_speed_tenths,
   input  wire logic [9:0]                         req_tire_pressure,
   input  wire logic                               req_door_open,
   input  wire logic                               req_belt_locked,
   input  wire logic [31:0]                        req_time_ms,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [1:0]                              rsp_event_kind,
   output logic [3:0]                              rsp_condition_id,
   output logic                                    rsp_severity,
   output logic [3:0]                              rsp_active_count,
   output logic [31:0]                             rsp_raised_total,
   output logic [31:0]                             rsp_raised_critical,
   output logic [31:0]                             rsp_raised_warning,
   output logic                                    rsp_last_event,
   input  wire logic                               csr_wr_en,
   input  wire logic [vam_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [vam_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   vam_pkg::action_vec_type actions;
   vam_pkg::push_ctl_type   ctl;
   vam_pkg::event_type      evt;
   vam_pkg::event_type      rsp_evt;
   logic                    push_ok;

   vam_classify u_classify (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .engine_temp   (req_engine_temp),
      .battery_mv    (req_battery_mv),
      .speed_tenths  (req_speed_tenths),
      .tire_pressure (req_tire_pressure),
      .door_open     (req_door_open),
      .belt_locked   (req_belt_locked),
      .actions       (actions)
   );

   vam_core #(
      .REMINDER_MS (REMINDER_MS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_valid && req_ready),
      .actions (actions),
      .time_ms (req_time_ms),
      .ready   (req_ready),
      .push_ok (push_ok),
      .ctl     (ctl),
      .evt     (evt)
   );

   vam_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .evt       (evt),
      .push_ok   (push_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_evt   (rsp_evt),
      .rsp_last  (rsp_last_event)
   );

   assign rsp_event_kind      = rsp_evt.kind;
   assign rsp_condition_id    = rsp_evt.cond_id;
   assign rsp_severity        = rsp_evt.severity;
   assign rsp_active_count    = rsp_evt.active_count;
   assign rsp_raised_total    = rsp_evt.raised_total;
   assign rsp_raised_critical = rsp_evt.raised_critical;
   assign rsp_raised_warning  = rsp_evt.raised_warning;

endmodule

`default_nettype wire

>>> src/vam_checker.sv
`default_nettype none

module vam_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_event_kind,
   input wire logic [3:0]  rsp_condition_id,
   input wire logic        rsp_severity,
   input wire logic [3:0]  rsp_active_count,
   input wire logic [31:0] rsp_raised_total,
   input wire logic [31:0] rsp_raised_critical,
   input wire logic [31:0] rsp_raised_warning,
   input wire logic        rsp_last_event
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_condition_id)
         && $stable(rsp_event_kind) && $stable(rsp_last_event))
      else $error("result changed while stalled");

   a_severity : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_severity == (rsp_condition_id == 4'd0 || rsp_condition_id == 4'd2
         || rsp_condition_id == 4'd4 || rsp_condition_id == 4'd5))
      else $error("severity does not match condition");

   a_totals : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_raised_total != 32'hFFFF_FFFF |->
         {1'b0, rsp_raised_total} == {1'b0, rsp_raised_critical}
                                   + {1'b0, rsp_raised_warning})
      else $error("raised counts disagree");

   a_raised_active : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == vam_pkg::EV_RAISED |->
         rsp_active_count != 4'd0 && rsp_active_count <= 4'd9 && rsp_condition_id <= 4'd8)
      else $error("raised event with bad active count");

endmodule

bind vehicle_alert_monitor_top vam_checker u_vam_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_event_kind      (rsp_event_kind),
   .rsp_condition_id    (rsp_condition_id),
   .rsp_severity        (rsp_severity),
   .rsp_active_count    (rsp_active_count),
   .rsp_raised_total    (rsp_raised_total),
   .rsp_raised_critical (rsp_raised_critical),
   .rsp_raised_warning  (rsp_raised_warning),
   .rsp_last_event      (rsp_last_event)
);

`default_nettype wire
